// ===== rtl/assert_macros.svh =====
// Assertion macros of the histogram block, used by minmax_range_histogram.
// No dependencies; included by the module that carries assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/mmrh_pkg.sv =====
// Shared constants of the min/max range histogram block.
// No dependencies; used by the top level for parameter defaults and fixed widths.
package mmrh_pkg;

   // Parameter defaults.
   localparam int DEF_MAX_SAMPLES  = 1024;
   localparam int DEF_MAX_BINS     = 32;
   localparam int DEF_SAMPLE_WIDTH = 16;

   // Bin count register.
   localparam int CFG_WIDTH = 6;
   localparam logic [CFG_WIDTH-1:0] CFG_RESET = 6'd10;

   // Bin counters saturate at all ones of this width.
   localparam int COUNT_WIDTH = 11;

endpackage

// ===== rtl/minmax_range_histogram.sv =====
// Equal-width histogram over the min..max range of a sample set.
//
// Input: a transaction is taken at a clock edge with start high and busy low.
// Each sample is written to the sample memory and folded into the running
// minimum and maximum; loading goes at one sample per cycle. A sample with
// req_final_sample high closes the set and busy rises for the binning pass.
// Samples past MAX_SAMPLES are dropped, but their final flag still counts.
// Pass: each held sample takes a sample read, a multiply, a bit-serial divide
// of QW = clog2(MAX_BINS + 1) quotient bits and a counter read-modify-write;
// the next sample starts only once the previous one is counted.
// Results: one transaction per bin, bins 0 upward, the last marked by
// rsp_final_bin. Each sits on the rsp_ ports for the one cycle that
// rsp_strobe is high; the receiver has no way to stall them. busy falls
// with the last result.
// Configuration: the bin count register is written through csr_valid/csr_ready
// (always ready) and must only change while busy is low.
// Reset (synchronous) empties the set and sets the bin count to ten.
// This file depends on mmrh_pkg, mmrh_div and assert_macros.svh.
`include "assert_macros.svh"

module minmax_range_histogram #(
   parameter int MAX_SAMPLES  = mmrh_pkg::DEF_MAX_SAMPLES,
   parameter int MAX_BINS     = mmrh_pkg::DEF_MAX_BINS,
   parameter int SAMPLE_WIDTH = mmrh_pkg::DEF_SAMPLE_WIDTH,
   localparam int BAW = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic signed [SAMPLE_WIDTH-1:0]     req_sample,
   input  logic                               req_final_sample,
   output logic                               rsp_strobe,
   output logic [BAW-1:0]                     rsp_bin_number,
   output logic [mmrh_pkg::COUNT_WIDTH-1:0]   rsp_bin_total,
   output logic                               rsp_final_bin,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [mmrh_pkg::CFG_WIDTH-1:0]     csr_data
);

   localparam int SW = SAMPLE_WIDTH;
   localparam int AW = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
   localparam int HW = $clog2(MAX_SAMPLES + 1);
   localparam int QW = $clog2(MAX_BINS + 1);
   localparam int NW = mmrh_pkg::COUNT_WIDTH;

   typedef enum logic [8:0] {
      ST_IDLE      = 9'b000000001,
      ST_RD_SAMPLE = 9'b000000010,
      ST_MUL       = 9'b000000100,
      ST_DIV_START = 9'b000001000,
      ST_DIV_WAIT  = 9'b000010000,
      ST_CNT_RD    = 9'b000100000,
      ST_CNT_WR    = 9'b001000000,
      ST_OUT_RD    = 9'b010000000,
      ST_OUT_WR    = 9'b100000000
   } state_type;

   state_type state_ff, state_in;

   logic [mmrh_pkg::CFG_WIDTH-1:0] csr_bins_ff;
   logic [QW-1:0]                  eff_bins;

   logic signed [SW-1:0] min_ff, min_in;
   logic signed [SW-1:0] max_ff, max_in;
   logic [HW-1:0]        held_ff, held_in;
   logic [SW:0]          span_wide;
   logic [SW-1:0]        span_ff;

   logic          accept;
   logic          store_ok;
   logic [HW-1:0] idx_ff;
   logic          last_sample;

   logic [SW-1:0] store_mem [MAX_SAMPLES];
   logic [SW-1:0] store_rd_ff;
   logic [SW:0]   off_wide;
   logic [SW-1:0] off;
   logic [SW+QW-1:0] prod_ff;

   logic          div_start;
   logic          div_done;
   logic [QW-1:0] div_quo;
   logic [QW-1:0] bin_sel;
   logic [BAW-1:0] bin_idx_ff;

   logic [NW-1:0]       cnt_mem [MAX_BINS];
   logic [MAX_BINS-1:0] vld_ff;
   logic [BAW-1:0]      cnt_addr;
   logic [NW-1:0]       cnt_rd_ff;
   logic                cnt_vld_rd_ff;
   logic [NW-1:0]       cnt_cur;
   logic [NW-1:0]       cnt_new;

   logic [BAW-1:0] k_ff;
   logic           last_bin;

   logic           rsp_strobe_ff;
   logic [BAW-1:0] rsp_bin_number_ff;
   logic [NW-1:0]  rsp_bin_total_ff;
   logic           rsp_final_bin_ff;

   // Configuration register; the port never stalls a write.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_bins_ff <= mmrh_pkg::CFG_RESET;
      end else if (csr_valid && csr_ready) begin
         csr_bins_ff <= csr_data;
      end
   end

   // Zero bins acts as one, anything above MAX_BINS acts as MAX_BINS.
   always_comb begin
      if (csr_bins_ff == '0) begin
         eff_bins = QW'(1);
      end else if (int'(csr_bins_ff) > MAX_BINS) begin
         eff_bins = QW'(MAX_BINS);
      end else begin
         eff_bins = QW'(csr_bins_ff);
      end
   end

   assign busy     = (state_ff != ST_IDLE);
   assign accept   = start && !busy;
   assign store_ok = (held_ff < HW'(MAX_SAMPLES));

   assign last_sample = (idx_ff == held_ff - HW'(1));
   assign last_bin    = (QW'(k_ff) == eff_bins - QW'(1));

   // Running extremes and fill count; the set is dropped after the last bin.
   always_comb begin
      min_in  = min_ff;
      max_in  = max_ff;
      held_in = held_ff;
      if (accept && store_ok) begin
         if (held_ff == '0) begin
            min_in = req_sample;
            max_in = req_sample;
         end else begin
            if (req_sample < min_ff) begin
               min_in = req_sample;
            end
            if (req_sample > max_ff) begin
               max_in = req_sample;
            end
         end
         held_in = held_ff + HW'(1);
      end
      if ((state_ff == ST_OUT_WR) && last_bin) begin
         min_in  = '0;
         max_in  = '0;
         held_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_ff  <= '0;
         max_ff  <= '0;
         held_ff <= '0;
      end else begin
         min_ff  <= min_in;
         max_ff  <= max_in;
         held_ff <= held_in;
      end
   end

   // The range always fits SW bits unsigned, as max is never below min.
   assign span_wide = {max_in[SW-1], max_in} - {min_in[SW-1], min_in};

   always_ff @(posedge clock) begin
      if (accept && req_final_sample) begin
         span_ff <= span_wide[SW-1:0];
      end
   end

   // Sample memory: written while loading, read by the binning pass.
   always_ff @(posedge clock) begin
      if (accept && store_ok) begin
         store_mem[held_ff[AW-1:0]] <= req_sample;
      end
      store_rd_ff <= store_mem[idx_ff[AW-1:0]];
   end

   // Offset from the minimum, scaled by the bin count.
   assign off_wide = {store_rd_ff[SW-1], store_rd_ff} - {min_ff[SW-1], min_ff};
   assign off      = off_wide[SW-1:0];

   always_ff @(posedge clock) begin
      if (state_ff == ST_MUL) begin
         prod_ff <= (SW+QW)'(off) * (SW+QW)'(eff_bins);
      end
   end

   assign div_start = (state_ff == ST_DIV_START);

   mmrh_div #(
      .DIVISOR_WIDTH (SW),
      .QUOTIENT_WIDTH(QW)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .numerator(prod_ff),
      .divisor  (span_ff),
      .done     (div_done),
      .quotient (div_quo)
   );

   // A zero range puts everything in bin 0; the maximum lands in the top bin.
   always_comb begin
      if (span_ff == '0) begin
         bin_sel = '0;
      end else if (div_quo >= eff_bins) begin
         bin_sel = eff_bins - QW'(1);
      end else begin
         bin_sel = div_quo;
      end
   end

   always_ff @(posedge clock) begin
      if ((state_ff == ST_DIV_WAIT) && div_done) begin
         bin_idx_ff <= BAW'(bin_sel);
      end
   end

   // Bin counter memory. Entries without a valid bit read as zero, so
   // clearing the valid bits at the start of each pass clears the bank.
   assign cnt_addr = (state_ff == ST_OUT_RD) ? k_ff : bin_idx_ff;
   assign cnt_cur  = cnt_vld_rd_ff ? cnt_rd_ff : '0;
   assign cnt_new  = (cnt_cur == '1) ? cnt_cur : cnt_cur + NW'(1);

   always_ff @(posedge clock) begin
      if (state_ff == ST_CNT_WR) begin
         cnt_mem[bin_idx_ff] <= cnt_new;
      end
      cnt_rd_ff     <= cnt_mem[cnt_addr];
      cnt_vld_rd_ff <= vld_ff[cnt_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (accept && req_final_sample) begin
         vld_ff <= '0;
      end else if (state_ff == ST_CNT_WR) begin
         vld_ff[bin_idx_ff] <= 1'b1;
      end
   end

   // Pass sequencer: one sample at a time through read, scale, divide and
   // count, then each bin out; a counter access ends before the next starts.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && req_final_sample) begin
               state_in = ST_RD_SAMPLE;
            end
         end
         ST_RD_SAMPLE: state_in = ST_MUL;
         ST_MUL:       state_in = ST_DIV_START;
         ST_DIV_START: state_in = ST_DIV_WAIT;
         ST_DIV_WAIT: begin
            if (div_done) begin
               state_in = ST_CNT_RD;
            end
         end
         ST_CNT_RD: state_in = ST_CNT_WR;
         ST_CNT_WR: begin
            state_in = last_sample ? ST_OUT_RD : ST_RD_SAMPLE;
         end
         ST_OUT_RD: state_in = ST_OUT_WR;
         ST_OUT_WR: begin
            state_in = last_bin ? ST_IDLE : ST_OUT_RD;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Sample and bin indexes of the pass.
   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
         k_ff   <= '0;
      end else begin
         if (accept && req_final_sample) begin
            idx_ff <= '0;
         end else if (state_ff == ST_CNT_WR) begin
            idx_ff <= idx_ff + HW'(1);
         end
         if ((state_ff == ST_CNT_WR) && last_sample) begin
            k_ff <= '0;
         end else if (state_ff == ST_OUT_WR) begin
            k_ff <= k_ff + BAW'(1);
         end
      end
   end

   // Result registers: one strobed transaction per bin.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= (state_ff == ST_OUT_WR);
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_OUT_WR) begin
         rsp_bin_number_ff <= k_ff;
         rsp_bin_total_ff  <= cnt_cur;
         rsp_final_bin_ff  <= last_bin;
      end
   end

   assign rsp_strobe     = rsp_strobe_ff;
   assign rsp_bin_number = rsp_bin_number_ff;
   assign rsp_bin_total  = rsp_bin_total_ff;
   assign rsp_final_bin  = rsp_final_bin_ff;

   // Checks on the sequencer and the bookkeeping.
   `ASSERT_IMPLY(a_strobe_src, clock, reset, rsp_strobe_ff, $past(state_ff) == ST_OUT_WR, "result strobe without a bin read")
   `ASSERT_IMPLY(a_held_bound, clock, reset, 1'b1, held_ff <= HW'(MAX_SAMPLES), "sample count beyond memory depth")
   `ASSERT_IMPLY(a_bin_range, clock, reset, state_ff == ST_CNT_WR, QW'(bin_idx_ff) < eff_bins, "counter update outside the bins in use")
   `ASSERT_IMPLY(a_final_drop, clock, reset, rsp_strobe_ff && rsp_final_bin_ff, held_ff == '0, "sample set kept after the last bin")
   `ASSERT_NEXT(a_pass_start, clock, reset, accept && req_final_sample, state_ff == ST_RD_SAMPLE, "final sample did not start the pass")

endmodule

// ===== rtl/mmrh_div.sv =====
// Bit-serial restoring divider with a short quotient, one quotient bit per cycle.
// Stand-alone; instantiated by minmax_range_histogram.
module mmrh_div #(
   parameter int DIVISOR_WIDTH  = 16,
   parameter int QUOTIENT_WIDTH = 6
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    start,
   input  logic [DIVISOR_WIDTH+QUOTIENT_WIDTH-1:0] numerator,
   input  logic [DIVISOR_WIDTH-1:0]                divisor,
   output logic                                    done,
   output logic [QUOTIENT_WIDTH-1:0]               quotient
);

   localparam int DW = DIVISOR_WIDTH;
   localparam int QW = QUOTIENT_WIDTH;
   localparam int CW = $clog2(QW + 1);

   logic          active_ff;
   logic          done_ff;
   logic [CW-1:0] step_ff;
   logic [DW-1:0] rem_ff;
   logic [QW-1:0] num_ff;
   logic [QW-1:0] quo_ff;

   logic [DW:0]   trial;
   logic          fits;
   logic [DW-1:0] rem_in;

   // One trial subtraction: bring down the next numerator bit and compare.
   always_comb begin
      trial  = {rem_ff, num_ff[QW-1]};
      fits   = (trial >= {1'b0, divisor});
      rem_in = fits ? DW'(trial - {1'b0, divisor}) : trial[DW-1:0];
   end

   // Control: busy flag and the done pulse after the last step.
   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         done_ff   <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            active_ff <= 1'b1;
         end else if (active_ff && (step_ff == CW'(1))) begin
            active_ff <= 1'b0;
            done_ff   <= 1'b1;
         end
      end
   end

   // Datapath. The quotient is known to fit QW bits, so the high numerator
   // bits are below the divisor and form the first partial remainder.
   always_ff @(posedge clock) begin
      if (start) begin
         step_ff <= CW'(QW);
         rem_ff  <= numerator[DW+QW-1:QW];
         num_ff  <= numerator[QW-1:0];
      end else if (active_ff) begin
         step_ff <= step_ff - CW'(1);
         rem_ff  <= rem_in;
         num_ff  <= num_ff << 1;
         quo_ff  <= QW'({quo_ff, fits});
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule
